[hw/rtl/canopen_lss_slave_responder_unit_assert.svh]
// ---------------------------------------------------------------------------
// LSS responder assertion macros
// Shared concurrent assertion forms for the LSS responder RTL.
// ---------------------------------------------------------------------------
`ifndef CANOPEN_LSS_SLAVE_RESPONDER_UNIT_ASSERT_SVH
`define CANOPEN_LSS_SLAVE_RESPONDER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("LSS responder check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("LSS responder check failed");

`endif

[hw/rtl/lss_resp_pkg.sv]
// ---------------------------------------------------------------------------
// LSS responder package
// Types, command codes and helper functions shared by the LSS responder.
// ---------------------------------------------------------------------------
package lss_resp_pkg;

  localparam logic [10:0] LSS_RX_ID      = 11'h7E5;
  localparam logic [3:0]  LSS_FRAME_LEN  = 4'd8;
  localparam logic [7:0]  NODE_UNCONF    = 8'hFF;
  localparam logic [7:0]  NODE_ID_LIMIT  = 8'h80;
  localparam logic [3:0]  RESET_BITRATE  = 4'd2;
  localparam logic [7:0]  MAX_BITRATE    = 8'd8;
  localparam logic [7:0]  RSVD_BITRATE   = 8'd5;
  localparam logic [5:0]  MATCH_ALL      = 6'h3F;
  localparam int          CFG_ADDR_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_VENDOR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PRODUCT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REVISION = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SERIAL   = 3'd3;

  // Command specifiers.
  localparam logic [7:0] CMD_SWITCH_GLOBAL = 8'h04;
  localparam logic [7:0] CMD_CFG_NODE      = 8'h11;
  localparam logic [7:0] CMD_CFG_BIT       = 8'h13;
  localparam logic [7:0] CMD_ACTIVATE      = 8'h15;
  localparam logic [7:0] CMD_STORE         = 8'h17;
  localparam logic [7:0] CMD_SEL_VENDOR    = 8'h40;
  localparam logic [7:0] CMD_SEL_PRODUCT   = 8'h41;
  localparam logic [7:0] CMD_SEL_REVISION  = 8'h42;
  localparam logic [7:0] CMD_SEL_SERIAL    = 8'h43;
  localparam logic [7:0] CMD_SEL_REPLY     = 8'h44;
  localparam logic [7:0] CMD_IDR_VENDOR    = 8'h46;
  localparam logic [7:0] CMD_IDR_PRODUCT   = 8'h47;
  localparam logic [7:0] CMD_IDR_REV_LO    = 8'h48;
  localparam logic [7:0] CMD_IDR_REV_HI    = 8'h49;
  localparam logic [7:0] CMD_IDR_SER_LO    = 8'h4A;
  localparam logic [7:0] CMD_IDR_SER_HI    = 8'h4B;
  localparam logic [7:0] CMD_IDR_NONCFG    = 8'h4C;
  localparam logic [7:0] CMD_IDR_REPLY     = 8'h4F;
  localparam logic [7:0] CMD_NONCFG_REPLY  = 8'h50;
  localparam logic [7:0] CMD_INQ_VENDOR    = 8'h5A;
  localparam logic [7:0] CMD_INQ_PRODUCT   = 8'h5B;
  localparam logic [7:0] CMD_INQ_REVISION  = 8'h5C;
  localparam logic [7:0] CMD_INQ_SERIAL    = 8'h5D;
  localparam logic [7:0] CMD_INQ_NODE      = 8'h5E;

  // Identity match kinds, in chain order.
  localparam logic [2:0] KIND_VENDOR  = 3'd0;
  localparam logic [2:0] KIND_PRODUCT = 3'd1;
  localparam logic [2:0] KIND_REV_LO  = 3'd2;
  localparam logic [2:0] KIND_REV_HI  = 3'd3;
  localparam logic [2:0] KIND_SER_LO  = 3'd4;
  localparam logic [2:0] KIND_SER_HI  = 3'd5;

  typedef struct packed {
    logic        nmt_in_init;
    logic [31:0] payload;
    logic [7:0]  command_byte;
    logic [3:0]  frame_length;
    logic [10:0] frame_id;
  } item_t;

  typedef struct packed {
    logic        config_mode;
    logic        store_request;
    logic [15:0] activate_delay_ms;
    logic        activate_request;
    logic [3:0]  bitrate_index;
    logic [7:0]  pending_node_id;
    logic [7:0]  active_node_id;
    logic        init_done;
    logic [31:0] reply_data;
    logic [7:0]  reply_command;
    logic        reply_valid;
    logic        frame_accepted;
  } result_t;

  typedef struct packed {
    logic        mode;
    logic [5:0]  match;
    logic [7:0]  pending_node;
    logic [3:0]  pending_bitrate;
    logic [7:0]  active_node;
  } state_t;

  typedef struct packed {
    logic [31:0] vendor_id;
    logic [31:0] product_code;
    logic [31:0] revision_number;
    logic [31:0] serial_number;
  } ident_t;

  localparam state_t STATE_RESET = '{
    mode:            1'b0,
    match:           6'd0,
    pending_node:    NODE_UNCONF,
    pending_bitrate: RESET_BITRATE,
    active_node:     NODE_UNCONF
  };

  // One step of the identity match chain. A step only counts when all
  // earlier bits are already set; a miss clears the whole chain.
  function automatic logic [5:0] match_step(input logic [5:0] prog,
                                            input logic [2:0] kind,
                                            input logic [5:0] hits);
    logic [5:0] bit_k;
    logic [5:0] need;
    bit_k = 6'd1 << kind;
    need  = bit_k - 6'd1;
    if ((prog & need) != need) begin
      match_step = prog;
    end else if ((hits & bit_k) != 6'd0) begin
      match_step = (prog | bit_k) & MATCH_ALL;
    end else begin
      match_step = 6'd0;
    end
  endfunction

endpackage

[hw/rtl/lss_resp_match.sv]
// ---------------------------------------------------------------------------
// LSS responder identity match
// Compares the payload with the identity and advances the match chain.
// ---------------------------------------------------------------------------
module lss_resp_match
  import lss_resp_pkg::*;
(
  input  logic [7:0]  cmd,
  input  logic [31:0] pay,
  input  ident_t      ident,
  input  logic [5:0]  prog,
  output logic [5:0]  prog_nxt
);

  logic [5:0] hits;

  assign hits[0] = ident.vendor_id == pay;
  assign hits[1] = ident.product_code == pay;
  assign hits[2] = ident.revision_number >= pay;
  assign hits[3] = ident.revision_number <= pay;
  assign hits[4] = ident.serial_number >= pay;
  assign hits[5] = ident.serial_number <= pay;

  // Range commands of the selective switch take the low and the high bound
  // in one word, the second step seeing the first step's result.
  always_comb begin
    case (cmd)
      CMD_SEL_VENDOR:   prog_nxt = match_step(prog, KIND_VENDOR, hits);
      CMD_SEL_PRODUCT:  prog_nxt = match_step(prog, KIND_PRODUCT, hits);
      CMD_SEL_REVISION: prog_nxt = match_step(match_step(prog, KIND_REV_LO, hits),
                                              KIND_REV_HI, hits);
      CMD_SEL_SERIAL:   prog_nxt = match_step(match_step(prog, KIND_SER_LO, hits),
                                              KIND_SER_HI, hits);
      CMD_IDR_VENDOR:   prog_nxt = match_step(prog, KIND_VENDOR, hits);
      CMD_IDR_PRODUCT:  prog_nxt = match_step(prog, KIND_PRODUCT, hits);
      CMD_IDR_REV_LO:   prog_nxt = match_step(prog, KIND_REV_LO, hits);
      CMD_IDR_REV_HI:   prog_nxt = match_step(prog, KIND_REV_HI, hits);
      CMD_IDR_SER_LO:   prog_nxt = match_step(prog, KIND_SER_LO, hits);
      CMD_IDR_SER_HI:   prog_nxt = match_step(prog, KIND_SER_HI, hits);
      default:          prog_nxt = prog;
    endcase
  end

endmodule

[hw/rtl/lss_resp_step.sv]
// ---------------------------------------------------------------------------
// LSS responder command step
// Decodes one received frame against the current state and forms the reply
// and the next state.
// ---------------------------------------------------------------------------
module lss_resp_step
  import lss_resp_pkg::*;
(
  input  item_t   item,
  input  state_t  st,
  input  ident_t  ident,
  output state_t  st_nxt,
  output result_t res
);

  logic [7:0] b1;
  logic [7:0] b2;
  logic       acc;
  logic [5:0] prog_nxt;

  assign b1  = item.payload[7:0];
  assign b2  = item.payload[15:8];
  assign acc = (item.frame_id == LSS_RX_ID) && (item.frame_length == LSS_FRAME_LEN);

  lss_resp_match u_match (
    .cmd      (item.command_byte),
    .pay      (item.payload),
    .ident    (ident),
    .prog     (st.match),
    .prog_nxt (prog_nxt)
  );

  always_comb begin
    st_nxt = st;
    res    = '0;
    res.frame_accepted = acc;
    if (acc) begin
      case (item.command_byte)
        CMD_SWITCH_GLOBAL: begin
          if (b1 <= 8'd1) begin
            st_nxt.mode = b1[0];
            // Leaving configuration during NMT init commits the new node id.
            if (st.mode && !b1[0] && item.nmt_in_init && st.pending_node != NODE_UNCONF) begin
              st_nxt.active_node = st.pending_node;
              res.init_done      = 1'b1;
            end
          end
        end
        CMD_CFG_NODE: begin
          if (st.mode) begin
            if ((b1 != 8'd0 && b1 < NODE_ID_LIMIT) || b1 == NODE_UNCONF) begin
              st_nxt.pending_node = b1;
            end else begin
              res.reply_data = 32'd1;
            end
            res.reply_valid   = 1'b1;
            res.reply_command = CMD_CFG_NODE;
          end
        end
        CMD_CFG_BIT: begin
          if (st.mode) begin
            if (b1 == 8'd0 && b2 <= MAX_BITRATE && b2 != RSVD_BITRATE) begin
              st_nxt.pending_bitrate = b2[3:0];
            end else begin
              res.reply_data = 32'd1;
            end
            res.reply_valid   = 1'b1;
            res.reply_command = CMD_CFG_BIT;
          end
        end
        CMD_ACTIVATE: begin
          if (st.mode) begin
            res.activate_request  = 1'b1;
            res.activate_delay_ms = item.payload[15:0];
          end
        end
        CMD_STORE: begin
          if (st.mode) begin
            res.store_request = 1'b1;
          end
        end
        CMD_SEL_VENDOR, CMD_SEL_PRODUCT, CMD_SEL_REVISION, CMD_SEL_SERIAL: begin
          st_nxt.match = prog_nxt;
          if (prog_nxt == MATCH_ALL) begin
            st_nxt.match      = 6'd0;
            st_nxt.mode       = 1'b1;
            res.reply_valid   = 1'b1;
            res.reply_command = CMD_SEL_REPLY;
          end
        end
        CMD_IDR_VENDOR, CMD_IDR_PRODUCT, CMD_IDR_REV_LO, CMD_IDR_REV_HI,
        CMD_IDR_SER_LO, CMD_IDR_SER_HI: begin
          st_nxt.match = prog_nxt;
          if (prog_nxt == MATCH_ALL) begin
            st_nxt.match      = 6'd0;
            res.reply_valid   = 1'b1;
            res.reply_command = CMD_IDR_REPLY;
          end
        end
        CMD_IDR_NONCFG: begin
          if (st.mode && item.nmt_in_init) begin
            res.reply_valid   = 1'b1;
            res.reply_command = CMD_NONCFG_REPLY;
          end
        end
        CMD_INQ_VENDOR, CMD_INQ_PRODUCT, CMD_INQ_REVISION, CMD_INQ_SERIAL,
        CMD_INQ_NODE: begin
          if (st.mode) begin
            res.reply_valid   = 1'b1;
            res.reply_command = item.command_byte;
            case (item.command_byte)
              CMD_INQ_VENDOR:   res.reply_data = ident.vendor_id;
              CMD_INQ_PRODUCT:  res.reply_data = ident.product_code;
              CMD_INQ_REVISION: res.reply_data = ident.revision_number;
              CMD_INQ_SERIAL:   res.reply_data = ident.serial_number;
              default:          res.reply_data = {24'd0, st.active_node};
            endcase
          end
        end
        default: begin
        end
      endcase
    end
    res.active_node_id  = st_nxt.active_node;
    res.pending_node_id = st_nxt.pending_node;
    res.bitrate_index   = st_nxt.pending_bitrate;
    res.config_mode     = st_nxt.mode;
  end

endmodule

[hw/rtl/canopen_lss_slave_responder_unit.sv]
// ---------------------------------------------------------------------------
// CANopen LSS slave responder
// Every received frame word gives exactly one result word, one per cycle at
// full rate while the output is not stalled. A word is held in the input
// register, is decoded there in a single pass, and the result plus the
// updated LSS state are written together into the output register, so a
// new word may enter while the last one is decoded. The input register
// takes a new word whenever it is empty or the output register is free or
// being drained. Writes to other config addresses are ignored; reset always
// brings the active node id to 255 and the pending bit-timing index to 2.
// ---------------------------------------------------------------------------
`include "canopen_lss_slave_responder_unit_assert.svh"

module canopen_lss_slave_responder_unit
  import lss_resp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_wdata,
  // Received frames.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // From bit 0: frame_id, frame_length, command_byte, payload, nmt_in_init.
  input  logic [55:0]           in_tdata,
  // Results.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // From bit 0: frame_accepted, reply_valid, reply_command, reply_data,
  // init_done, active_node_id, pending_node_id, bitrate_index,
  // activate_request, activate_delay_ms, store_request, config_mode, zeros.
  output logic [87:0]           out_tdata
);

  ident_t  ident_r;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  logic    item_vld_r;
  result_t res_nxt;
  result_t res_r;
  logic    res_vld_r;
  logic    advance;

  assign advance   = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VENDOR:   ident_r.vendor_id       <= cfg_wdata;
        REG_PRODUCT:  ident_r.product_code    <= cfg_wdata;
        REG_REVISION: ident_r.revision_number <= cfg_wdata;
        REG_SERIAL:   ident_r.serial_number   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata);
    end
  end

  lss_resp_step u_step (
    .item   (item_r),
    .st     (state_r),
    .ident  (ident_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // State moves only when the word's result is committed to the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= STATE_RESET;
      res_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r   <= state_nxt;
        res_vld_r <= 1'b1;
      end else if (out_tready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {6'd0, res_r};

  `LSS_ASSERT_IMPL(a_reply_needs_accept, res_vld_r && res_r.reply_valid, res_r.frame_accepted)
  `LSS_ASSERT_IMPL(a_init_done_commit, res_vld_r && res_r.init_done,
                   !res_r.config_mode && res_r.active_node_id == res_r.pending_node_id)
  `LSS_ASSERT_IMPL(a_match_contiguous, 1'b1, (state_r.match & (state_r.match + 6'd1)) == 6'd0)
  `LSS_ASSERT_NEXT(a_reject_keeps_state, advance && !res_nxt.frame_accepted,
                   state_r == $past(state_r))

endmodule

[verif/tb_canopen_lss_slave_responder_unit.sv]
// ---------------------------------------------------------------------------
// LSS slave responder testbench
// Streams received CAN frame words into the responder and predicts the
// result word of each one from a behavioral copy of the LSS state. Each
// result is compared field by field with the oldest prediction. The
// identity registers change between phases while the block is idle. Both
// stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_canopen_lss_slave_responder_unit
  import lss_resp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] REG_START_NODE    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_START_BITRATE = 3'd5;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 230;

  // Predicts the result word of each frame and checks the words that come
  // back against those predictions in order.
  class lss_reply_tracker;
    logic        mode         = 1'b0;
    logic [5:0]  match        = 6'd0;
    logic [7:0]  pend_node    = NODE_UNCONF;
    logic [3:0]  pend_rate    = RESET_BITRATE;
    logic [7:0]  active       = NODE_UNCONF;
    logic [31:0] vendor       = '0;
    logic [31:0] product      = '0;
    logic [31:0] revision     = '0;
    logic [31:0] serial       = '0;
    result_t     pending_results[$];
    int          errors       = 0;
    int          frames       = 0;
    int          accepted     = 0;
    int          replies      = 0;
    int          init_pulses  = 0;
    int          requests     = 0;

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_VENDOR:   vendor = val;
        REG_PRODUCT:  product = val;
        REG_REVISION: revision = val;
        REG_SERIAL:   serial = val;
        // The responder ignores writes to the start node and start bit-timing addresses.
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void chain_step(logic [2:0] kind, logic [31:0] want);
      logic [5:0] bit_k;
      logic [5:0] need;
      logic       hit;
      bit_k = 6'd1 << kind;
      need  = bit_k - 6'd1;
      if ((match & need) != need) return;
      case (kind)
        KIND_VENDOR:  hit = (vendor == want);
        KIND_PRODUCT: hit = (product == want);
        KIND_REV_LO:  hit = (revision >= want);
        KIND_REV_HI:  hit = (revision <= want);
        KIND_SER_LO:  hit = (serial >= want);
        default:      hit = (serial <= want);
      endcase
      match = hit ? (match | bit_k) : 6'd0;
    endfunction

    function void note_frame(item_t f);
      result_t    r;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] off;
      logic       was_cfg;
      r       = '0;
      b1      = f.payload[7:0];
      b2      = f.payload[15:8];
      was_cfg = mode;
      r.frame_accepted = (f.frame_id == LSS_RX_ID) && (f.frame_length == LSS_FRAME_LEN);
      if (r.frame_accepted) begin
        case (f.command_byte)
          CMD_SWITCH_GLOBAL: begin
            if (b1 <= 8'd1) begin
              if (mode && b1 == 8'd0 && f.nmt_in_init && pend_node != NODE_UNCONF) begin
                active      = pend_node;
                r.init_done = 1'b1;
              end
              mode = b1[0];
            end
          end
          CMD_CFG_NODE: begin
            if (was_cfg) begin
              if ((b1 != 8'd0 && b1 < NODE_ID_LIMIT) || b1 == NODE_UNCONF) pend_node = b1;
              else r.reply_data = 32'd1;
              r.reply_valid   = 1'b1;
              r.reply_command = CMD_CFG_NODE;
            end
          end
          CMD_CFG_BIT: begin
            if (was_cfg) begin
              if (b1 == 8'd0 && b2 <= MAX_BITRATE && b2 != RSVD_BITRATE) pend_rate = b2[3:0];
              else r.reply_data = 32'd1;
              r.reply_valid   = 1'b1;
              r.reply_command = CMD_CFG_BIT;
            end
          end
          CMD_ACTIVATE: begin
            if (was_cfg) begin
              r.activate_request  = 1'b1;
              r.activate_delay_ms = f.payload[15:0];
            end
          end
          CMD_STORE: r.store_request = was_cfg;
          CMD_SEL_VENDOR, CMD_SEL_PRODUCT, CMD_SEL_REVISION, CMD_SEL_SERIAL: begin
            // Revision and serial each carry both bounds in one frame.
            case (f.command_byte)
              CMD_SEL_VENDOR:   chain_step(KIND_VENDOR, f.payload);
              CMD_SEL_PRODUCT:  chain_step(KIND_PRODUCT, f.payload);
              CMD_SEL_REVISION: begin
                chain_step(KIND_REV_LO, f.payload);
                chain_step(KIND_REV_HI, f.payload);
              end
              default: begin
                chain_step(KIND_SER_LO, f.payload);
                chain_step(KIND_SER_HI, f.payload);
              end
            endcase
            if (match == MATCH_ALL) begin
              match           = 6'd0;
              mode            = 1'b1;
              r.reply_valid   = 1'b1;
              r.reply_command = CMD_SEL_REPLY;
            end
          end
          CMD_IDR_VENDOR, CMD_IDR_PRODUCT, CMD_IDR_REV_LO, CMD_IDR_REV_HI,
          CMD_IDR_SER_LO, CMD_IDR_SER_HI: begin
            off = f.command_byte - CMD_IDR_VENDOR;
            chain_step(off[2:0], f.payload);
            if (match == MATCH_ALL) begin
              match           = 6'd0;
              r.reply_valid   = 1'b1;
              r.reply_command = CMD_IDR_REPLY;
            end
          end
          CMD_IDR_NONCFG: begin
            if (was_cfg && f.nmt_in_init) begin
              r.reply_valid   = 1'b1;
              r.reply_command = CMD_NONCFG_REPLY;
            end
          end
          CMD_INQ_VENDOR, CMD_INQ_PRODUCT, CMD_INQ_REVISION, CMD_INQ_SERIAL,
          CMD_INQ_NODE: begin
            if (was_cfg) begin
              r.reply_valid   = 1'b1;
              r.reply_command = f.command_byte;
              case (f.command_byte)
                CMD_INQ_VENDOR:   r.reply_data = vendor;
                CMD_INQ_PRODUCT:  r.reply_data = product;
                CMD_INQ_REVISION: r.reply_data = revision;
                CMD_INQ_SERIAL:   r.reply_data = serial;
                default:          r.reply_data = {24'd0, active};
              endcase
            end
          end
          default: ;
        endcase
      end
      r.active_node_id  = active;
      r.pending_node_id = pend_node;
      r.bitrate_index   = pend_rate;
      r.config_mode     = mode;
      pending_results.push_back(r);
      frames++;
      if (r.frame_accepted) accepted++;
      if (r.reply_valid) replies++;
      if (r.init_done) init_pulses++;
      if (r.activate_request || r.store_request) requests++;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] result mismatch: %s", $realtime, msg);
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) flag($sformatf("%s expected %0h, got %0h", name, e, a));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result word %0h arrived with none outstanding", got));
        return;
      end
      want = pending_results.pop_front();
      cmp_field("frame_accepted", want.frame_accepted, got.frame_accepted);
      cmp_field("reply_valid", want.reply_valid, got.reply_valid);
      cmp_field("reply_command", want.reply_command, got.reply_command);
      cmp_field("reply_data", want.reply_data, got.reply_data);
      cmp_field("init_done", want.init_done, got.init_done);
      cmp_field("active_node_id", want.active_node_id, got.active_node_id);
      cmp_field("pending_node_id", want.pending_node_id, got.pending_node_id);
      cmp_field("bitrate_index", want.bitrate_index, got.bitrate_index);
      cmp_field("activate_request", want.activate_request, got.activate_request);
      cmp_field("activate_delay_ms", want.activate_delay_ms, got.activate_delay_ms);
      cmp_field("store_request", want.store_request, got.store_request);
      cmp_field("config_mode", want.config_mode, got.config_mode);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [31:0]           cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [55:0]           in_tdata;   // From bit 0: frame_id, frame_length, command_byte,
                                     // payload, nmt_in_init.
  logic                  out_tvalid;
  logic                  out_tready;
  logic [87:0]           out_tdata;  // From bit 0: frame_accepted, reply_valid,
                                     // reply_command, reply_data, init_done,
                                     // active_node_id, pending_node_id, bitrate_index,
                                     // activate_request, activate_delay_ms,
                                     // store_request, config_mode, zeros.

  lss_reply_tracker sb;
  logic [31:0]      ident [4];
  logic             tx_steady;
  logic             rx_steady;
  logic             hold_rx;
  int               frames_sent;
  int unsigned      cycle_count = 0;

  canopen_lss_slave_responder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic item_t lss_frame(logic [7:0] cmd, logic [31:0] p, logic init);
    item_t f;
    f.frame_id     = LSS_RX_ID;
    f.frame_length = LSS_FRAME_LEN;
    f.command_byte = cmd;
    f.payload      = p;
    f.nmt_in_init  = init;
    return f;
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 21))
      0, 1:    return CMD_SWITCH_GLOBAL;
      2:       return CMD_CFG_NODE;
      3:       return CMD_CFG_BIT;
      4:       return CMD_ACTIVATE;
      5:       return CMD_STORE;
      6:       return CMD_SEL_VENDOR;
      7:       return CMD_SEL_PRODUCT;
      8:       return CMD_SEL_REVISION;
      9:       return CMD_SEL_SERIAL;
      10:      return CMD_IDR_VENDOR;
      11:      return CMD_IDR_PRODUCT;
      12:      return CMD_IDR_REV_LO;
      13:      return CMD_IDR_REV_HI;
      14:      return CMD_IDR_SER_LO;
      15:      return CMD_IDR_SER_HI;
      16:      return CMD_IDR_NONCFG;
      17:      return CMD_INQ_VENDOR;
      18:      return CMD_INQ_PRODUCT;
      19:      return CMD_INQ_REVISION;
      20:      return ($urandom_range(0, 1) == 1) ? CMD_INQ_SERIAL : CMD_INQ_NODE;
      default: return 8'($urandom);
    endcase
  endfunction

  // An identity word that is right in three of eight draws and otherwise off by one, zero, all ones or random.
  function automatic logic [31:0] id_word(logic [31:0] v);
    case ($urandom_range(0, 7))
      0:       return v + 32'd1;
      1:       return v - 32'd1;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom;
      default: return v;
    endcase
  endfunction

  function automatic logic [31:0] shaped_payload(logic [7:0] cmd);
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      case (cmd)
        CMD_SWITCH_GLOBAL: p[7:0] = 8'($urandom_range(0, 1));
        CMD_CFG_NODE:      p[7:0] = ($urandom_range(0, 3) != 0) ?
                                    8'($urandom_range(1, 127)) : NODE_UNCONF;
        CMD_CFG_BIT: begin
          p[7:0]  = 8'd0;
          p[15:8] = 8'($urandom_range(0, 9));
        end
        CMD_SEL_VENDOR, CMD_IDR_VENDOR:   p = id_word(ident[0]);
        CMD_SEL_PRODUCT, CMD_IDR_PRODUCT: p = id_word(ident[1]);
        CMD_SEL_REVISION, CMD_IDR_REV_LO, CMD_IDR_REV_HI: p = id_word(ident[2]);
        CMD_SEL_SERIAL, CMD_IDR_SER_LO, CMD_IDR_SER_HI:   p = id_word(ident[3]);
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic send_frame(item_t f);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= f;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_frame(f);
    frames_sent++;
  endtask

  // Waits until every frame sent so far has its result word back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic load_identity(logic [31:0] v, logic [31:0] p, logic [31:0] r,
                               logic [31:0] s, logic [7:0] node, logic [3:0] rate);
    ident[0] = v;
    ident[1] = p;
    ident[2] = r;
    ident[3] = s;
    write_reg(REG_VENDOR, v);
    write_reg(REG_PRODUCT, p);
    write_reg(REG_REVISION, r);
    write_reg(REG_SERIAL, s);
    write_reg(REG_START_NODE, {24'd0, node});
    write_reg(REG_START_BITRATE, {28'd0, rate});
  endtask

  // Switch-selective needs the exact revision and serial, since each frame
  // carries the lower and the upper bound at once.
  task automatic sel_chain(logic good);
    send_frame(lss_frame(CMD_SEL_VENDOR, good ? ident[0] : id_word(ident[0]), 1'b0));
    send_frame(lss_frame(CMD_SEL_PRODUCT, good ? ident[1] : id_word(ident[1]), 1'b1));
    send_frame(lss_frame(CMD_SEL_REVISION, good ? ident[2] : id_word(ident[2]), 1'b0));
    send_frame(lss_frame(CMD_SEL_SERIAL, good ? ident[3] : id_word(ident[3]), 1'b1));
  endtask

  task automatic idr_chain(logic good);
    logic [31:0] w;
    logic [7:0]  c;
    int          idx;
    int          stop;
    stop = good ? 6 : $urandom_range(1, 6);
    for (int k = 0; k < stop; k++) begin
      idx = (k < 2) ? k : (k / 2 + 1);
      w   = ident[idx];
      // Widest bounds still match: zero below, all ones above.
      if (k >= 2 && $urandom_range(0, 2) == 0) w = (k % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
      if (!good) w = id_word(w);
      c = CMD_IDR_VENDOR + k[7:0];
      send_frame(lss_frame(c, w, ($urandom_range(0, 1) == 1)));
    end
  endtask

  task automatic random_sequence();
    item_t       f;
    logic [7:0]  c;
    logic [31:0] p;
    if ($urandom_range(0, 11) == 0) tx_steady = !tx_steady;
    case ($urandom_range(0, 9))
      0: begin
        f.frame_id     = 11'($urandom);
        f.frame_length = 4'($urandom);
        f.command_byte = pick_cmd();
        f.payload      = $urandom;
        f.nmt_in_init  = ($urandom_range(0, 1) == 1);
        case ($urandom_range(0, 2))
          0:       f.frame_id = LSS_RX_ID;
          1:       f.frame_length = LSS_FRAME_LEN;
          default: ;
        endcase
        send_frame(f);
      end
      1, 2, 3: begin
        c = pick_cmd();
        send_frame(lss_frame(c, shaped_payload(c), ($urandom_range(0, 1) == 1)));
      end
      4, 5: begin
        // Configuration session: enter, a few commands, leave.
        p      = $urandom;
        p[7:0] = 8'd1;
        send_frame(lss_frame(CMD_SWITCH_GLOBAL, p, ($urandom_range(0, 1) == 1)));
        repeat ($urandom_range(1, 4)) begin
          c = pick_cmd();
          send_frame(lss_frame(c, shaped_payload(c), ($urandom_range(0, 3) != 0)));
        end
        p      = $urandom;
        p[7:0] = 8'd0;
        send_frame(lss_frame(CMD_SWITCH_GLOBAL, p, ($urandom_range(0, 3) != 0)));
      end
      6, 7:    sel_chain(($urandom_range(0, 3) != 0));
      default: idr_chain(($urandom_range(0, 3) != 0));
    endcase
  endtask

  task automatic directed_frames();
    item_t f;
    f = lss_frame(CMD_SWITCH_GLOBAL, 32'd1, 1'b0);
    f.frame_id = LSS_RX_ID - 11'd1;
    send_frame(f);
    f = lss_frame(CMD_SWITCH_GLOBAL, 32'd1, 1'b0);
    f.frame_length = LSS_FRAME_LEN - 4'd1;
    send_frame(f);
    f = '0;
    send_frame(f);
    f = '1;
    send_frame(f);
    send_frame(lss_frame(CMD_CFG_NODE, 32'd5, 1'b1));          // waiting mode, ignored
    send_frame(lss_frame(CMD_SWITCH_GLOBAL, 32'd2, 1'b0));     // mode out of range
    send_frame(lss_frame(CMD_SWITCH_GLOBAL, 32'd1, 1'b0));
    send_frame(lss_frame(CMD_CFG_NODE, 32'h0000_0000, 1'b0));
    send_frame(lss_frame(CMD_CFG_NODE, 32'h0000_0080, 1'b0));
    send_frame(lss_frame(CMD_CFG_NODE, 32'hFFFF_FF7F, 1'b0));
    send_frame(lss_frame(CMD_CFG_BIT, 32'h0000_0001, 1'b0));   // table other than 0
    send_frame(lss_frame(CMD_CFG_BIT, 32'h0000_0500, 1'b0));   // reserved index
    send_frame(lss_frame(CMD_CFG_BIT, 32'h0000_0800, 1'b0));
    send_frame(lss_frame(CMD_ACTIVATE, 32'hFFFF_FFFF, 1'b0));
    send_frame(lss_frame(CMD_STORE, 32'h0, 1'b0));
    send_frame(lss_frame(CMD_INQ_VENDOR, 32'h0, 1'b0));
    send_frame(lss_frame(CMD_INQ_NODE, 32'h0, 1'b0));
    send_frame(lss_frame(CMD_IDR_NONCFG, 32'h0, 1'b1));
    send_frame(lss_frame(CMD_SWITCH_GLOBAL, 32'd0, 1'b1));     // leaves with a new node
    send_frame(lss_frame(CMD_SEL_SERIAL, ident[3], 1'b0));     // chain out of order
    sel_chain(1'b1);
    idr_chain(1'b1);
  endtask

  initial begin : result_sink
    int   stall;
    int   taken;
    logic held;
    out_tready = 1'b0;
    rx_steady  = 1'b0;
    taken      = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(result_t'(out_tdata[81:0]));
      taken++;
      if (taken % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    tx_steady   = 1'b0;
    hold_rx     = 1'b0;
    frames_sent = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    load_identity(32'h1234_5678, 32'h0000_0001, 32'h0000_0100, 32'hDEAD_BEEF, 8'd0, 4'd0);
    directed_frames();

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: load_identity(32'h0, 32'h0, 32'h0, 32'h0, 8'd255, 4'd8);
        1: load_identity(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         8'd0, 4'd0);
        4: load_identity($urandom, 32'h0, 32'hFFFF_FFFF, 32'h0, 8'd127, 4'd2);
        default: load_identity($urandom, $urandom, $urandom, $urandom,
                               8'($urandom), 4'($urandom_range(0, 8)));
      endcase
      if (ph == 2) begin
        // Receiver holds off while frames keep coming back to back.
        hold_rx   = 1'b1;
        tx_steady = 1'b1;
        repeat (24) send_frame(lss_frame(pick_cmd(), $urandom, ($urandom_range(0, 1) == 1)));
        tx_steady = 1'b0;
      end
      while (frames_sent < 30 + (ph + 1) * PHASE_WORDS) random_sequence();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d frames (%0d accepted) over 6 register settings: %0d replies,",
             sb.frames, sb.accepted, sb.replies);
    $display("%0d init-done pulses, %0d activate or store requests, %0d mismatches.",
             sb.init_pulses, sb.requests, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lss_resp_pkg.sv
hw/rtl/lss_resp_match.sv
hw/rtl/lss_resp_step.sv
hw/rtl/canopen_lss_slave_responder_unit.sv
verif/tb_canopen_lss_slave_responder_unit.sv
